[sv/pixel_vector_product_top_assert.svh]
// Assertion macros shared by the pixel vector product RTL.
`ifndef PIXEL_VECTOR_PRODUCT_TOP_ASSERT_SVH
`define PIXEL_VECTOR_PRODUCT_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge out of reset.
`define PVP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge out of reset.
`define PVP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pvp_pkg.sv]
// Shared types, codes and small tables of the pixel vector product block.
package pvp_pkg;

    localparam int WIDE_FIELDS   = 9;
    localparam int NARROW_FIELDS = 3;
    localparam int LANES         = NARROW_FIELDS;
    localparam int DATA_W        = 16;
    localparam int PROD_W        = 32;
    localparam int SUM_W         = PROD_W + 2;
    localparam int CH_W          = 5;
    localparam int WIDX_W        = 4;
    localparam int NIDX_W        = 2;

    // Product mode register codes
    localparam logic [1:0] MODE_ELEM  = 2'd0;
    localparam logic [1:0] MODE_INNER = 2'd1;
    localparam logic [1:0] MODE_OUTER = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_WIDE   = 2'd1;
    localparam logic [1:0] CFG_NARROW = 2'd2;

    // What the issue stage walks for one pixel
    typedef enum logic [1:0] {
        KIND_ELEM  = 2'd0,
        KIND_INNER = 2'd1,
        KIND_OUTER = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    // Control that travels with each result through the pipe
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
        logic            bad;
    } t_ctl;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0] t_value;

    // Quotient by three of a channel count
    function automatic logic [3:0] div3(input logic [3:0] v);
        logic [3:0] q;
        case (v)
            4'd0, 4'd1, 4'd2:    q = 4'd0;
            4'd3, 4'd4, 4'd5:    q = 4'd1;
            4'd6, 4'd7, 4'd8:    q = 4'd2;
            4'd9, 4'd10, 4'd11:  q = 4'd3;
            4'd12, 4'd13, 4'd14: q = 4'd4;
            default:             q = 4'd5;
        endcase
        return q;
    endfunction

    // Remainder by three of a channel count
    function automatic logic [1:0] mod3(input logic [3:0] v);
        logic [1:0] r;
        case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
            default:                              r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

[sv/pvp_mac.sv]
// Multiply and sum stages: lane products, then saturated sum into the output register.
module pvp_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  pvp_pkg::t_sample [pvp_pkg::LANES-1:0]  i_a,
    input  pvp_pkg::t_sample [pvp_pkg::LANES-1:0]  i_b,
    input  pvp_pkg::t_ctl                          i_ctl,
    output logic                                   o_valid,
    output pvp_pkg::t_value                        o_value,
    output pvp_pkg::t_ctl                          o_ctl
);

    logic                                          r_v2;
    logic signed [pvp_pkg::LANES-1:0][pvp_pkg::PROD_W-1:0] r_p2;
    pvp_pkg::t_ctl                                 r_ctl2;
    logic                                          r_v3;
    pvp_pkg::t_value                               r_val3;
    pvp_pkg::t_ctl                                 r_ctl3;
    logic signed [pvp_pkg::SUM_W-1:0]              n_sum;
    pvp_pkg::t_value                               n_sat;

    // Valid bits advance with the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    // Multiply each lane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < pvp_pkg::LANES; j++) begin
                r_p2[j] <= pvp_pkg::PROD_W'(i_a[j] * i_b[j]);
            end
            r_ctl2 <= i_ctl;
        end
    end

    // Sum the lanes and clip to the Q16.16 range
    always_comb begin
        n_sum = '0;
        for (int j = 0; j < pvp_pkg::LANES; j++) begin
            n_sum = n_sum + pvp_pkg::SUM_W'($signed(r_p2[j]));
        end
        if (n_sum > pvp_pkg::SUM_W'(signed'(32'sh7FFF_FFFF))) begin
            n_sat = 32'sh7FFF_FFFF;
        end else if (n_sum < pvp_pkg::SUM_W'(signed'(-33'sd2147483648))) begin
            n_sat = 32'sh8000_0000;
        end else begin
            n_sat = n_sum[pvp_pkg::PROD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val3 <= n_sat;
            r_ctl3 <= r_ctl2;
        end
    end

    assign o_valid = r_v3;
    assign o_value = r_val3;
    assign o_ctl   = r_ctl3;

endmodule

[sv/pixel_vector_product_top.sv]
// Top level of the pixel vector product: config registers, pixel holding stage, issue walk.
//
//   Port group   Dir  Handshake               Payload
//   i_s_*        in   i_s_tvalid/o_s_tready   one pixel: 9 wide + 3 narrow Q8.8 samples
//   o_m_*        out  o_m_tvalid/i_m_tready   one output channel, tlast on the final one
//   i_cfg_*      in   i_cfg_valid/o_cfg_ready register index and write data
//
// A pixel giving R results (R = 1..27) holds the issue stage until its last result issues,
// one result issued per cycle unless the output stalls; the next pixel is taken in the cycle
// its predecessor issues its last result. Results pass operand, product and sum registers.
// Reset is synchronous and clears valid bits and config registers to their defaults.
// A stalled output freezes the whole pipe; nothing is dropped or issued twice.
`include "pixel_vector_product_top_assert.svh"

module pixel_vector_product_top #(
    parameter int MAX_WIDE   = 9,
    parameter int MAX_NARROW = 3
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // wide_0..wide_8, then narrow_0..narrow_2, 16 bits each from bit 0 up
    input  logic [191:0] i_s_tdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // product_value [31:0], out_channel [36:32], zero fill [39:37]
    output logic [39:0]  o_m_tdata,
    // bad_shape
    output logic [0:0]   o_m_tuser,
    output logic         o_m_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [3:0]   i_cfg_data
);

    localparam int LIM_W = (MAX_WIDE < pvp_pkg::WIDE_FIELDS) ? MAX_WIDE : pvp_pkg::WIDE_FIELDS;
    localparam int LIM_N = (MAX_NARROW < pvp_pkg::NARROW_FIELDS) ?
                           MAX_NARROW : pvp_pkg::NARROW_FIELDS;

    // Config registers
    logic [1:0] r_mode;
    logic [3:0] r_wide_ch;
    logic [1:0] r_narrow_ch;

    // Held pixel and issue walk
    pvp_pkg::t_sample                      r_wide   [pvp_pkg::WIDE_FIELDS];
    pvp_pkg::t_sample                      r_narrow [pvp_pkg::NARROW_FIELDS];
    logic                                  r_busy;
    logic [pvp_pkg::WIDX_W-1:0]            r_aidx;
    logic [pvp_pkg::NIDX_W-1:0]            r_bidx;
    logic [pvp_pkg::CH_W-1:0]              r_ch;

    // Operand stage
    logic                                  r_v1;
    pvp_pkg::t_sample [pvp_pkg::LANES-1:0] r_a1;
    pvp_pkg::t_sample [pvp_pkg::LANES-1:0] r_b1;
    pvp_pkg::t_ctl                         r_ctl1;

    logic [3:0]                            w_eff;
    logic [1:0]                            n_eff;
    logic                                  shape_bad;
    pvp_pkg::t_kind                        kind;
    logic [pvp_pkg::CH_W-1:0]              total;
    logic                                  r_en;
    logic                                  issue;
    logic                                  issue_last;
    logic                                  s_accept;
    logic [pvp_pkg::CH_W-1:0]              ch_inc;
    logic [pvp_pkg::NIDX_W-1:0]            bidx_inc;
    logic                                  bidx_wrap;
    logic [pvp_pkg::WIDX_W-1:0]            n_aidx;
    logic [pvp_pkg::NIDX_W-1:0]            n_bidx;
    pvp_pkg::t_sample [pvp_pkg::LANES-1:0] n_a1;
    pvp_pkg::t_sample [pvp_pkg::LANES-1:0] n_b1;
    pvp_pkg::t_ctl                         n_ctl1;
    logic [4:0]                            lane_idx;

    logic                                  m_valid;
    pvp_pkg::t_value                       m_value;
    pvp_pkg::t_ctl                         m_ctl;

    // Accept register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= pvp_pkg::MODE_ELEM;
            r_wide_ch   <= 4'd3;
            r_narrow_ch <= 2'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pvp_pkg::CFG_MODE:   r_mode      <= i_cfg_data[1:0];
                pvp_pkg::CFG_WIDE:   r_wide_ch   <= i_cfg_data;
                pvp_pkg::CFG_NARROW: r_narrow_ch <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Clamp the counts and pick the walk
    always_comb begin
        if (r_wide_ch == 4'd0) begin
            w_eff = 4'd1;
        end else if (r_wide_ch > 4'(LIM_W)) begin
            w_eff = 4'(LIM_W);
        end else begin
            w_eff = r_wide_ch;
        end
        if (r_narrow_ch == 2'd0) begin
            n_eff = 2'd1;
        end else if (r_narrow_ch > 2'(LIM_N)) begin
            n_eff = 2'(LIM_N);
        end else begin
            n_eff = r_narrow_ch;
        end

        case (n_eff)
            2'd2:    shape_bad = w_eff[0];
            2'd3:    shape_bad = (pvp_pkg::mod3(w_eff) != 2'd0);
            default: shape_bad = 1'b0;
        endcase

        if (shape_bad) begin
            kind = pvp_pkg::KIND_BAD;
        end else if (n_eff == 2'd1 || r_mode == pvp_pkg::MODE_ELEM) begin
            kind = pvp_pkg::KIND_ELEM;
        end else if (r_mode == pvp_pkg::MODE_INNER) begin
            kind = pvp_pkg::KIND_INNER;
        end else if (r_mode == pvp_pkg::MODE_OUTER) begin
            kind = pvp_pkg::KIND_OUTER;
        end else begin
            kind = pvp_pkg::KIND_ELEM;
        end

        case (kind)
            pvp_pkg::KIND_ELEM:  total = pvp_pkg::CH_W'(w_eff);
            pvp_pkg::KIND_INNER: total = (n_eff == 2'd2) ? pvp_pkg::CH_W'(w_eff >> 1) :
                                         pvp_pkg::CH_W'(pvp_pkg::div3(w_eff));
            pvp_pkg::KIND_OUTER: total = pvp_pkg::CH_W'(6'(w_eff) * 6'(n_eff));
            default:             total = pvp_pkg::CH_W'(1);
        endcase
    end

    // Pipe advances unless the output holds a result nobody takes
    assign r_en       = !m_valid || i_m_tready;
    assign issue      = r_busy && r_en;
    assign ch_inc     = r_ch + pvp_pkg::CH_W'(1);
    assign issue_last = (ch_inc == total);
    assign o_s_tready = !r_busy || (r_en && issue_last);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Step the walk counters
    always_comb begin
        bidx_inc  = r_bidx + 2'd1;
        bidx_wrap = (bidx_inc == n_eff);
        n_aidx    = r_aidx;
        n_bidx    = r_bidx;
        case (kind)
            pvp_pkg::KIND_ELEM: begin
                n_aidx = r_aidx + 4'd1;
                n_bidx = bidx_wrap ? 2'd0 : bidx_inc;
            end
            pvp_pkg::KIND_INNER: begin
                n_aidx = r_aidx + 4'(n_eff);
            end
            pvp_pkg::KIND_OUTER: begin
                n_aidx = bidx_wrap ? r_aidx + 4'd1 : r_aidx;
                n_bidx = bidx_wrap ? 2'd0 : bidx_inc;
            end
            default: ;
        endcase
    end

    // Gather the lane operands for this result
    always_comb begin
        lane_idx = '0;
        for (int j = 0; j < pvp_pkg::LANES; j++) begin
            n_a1[j]  = '0;
            n_b1[j]  = '0;
            lane_idx = 5'(r_aidx) + 5'(j);
            if (kind == pvp_pkg::KIND_INNER) begin
                if (j < int'(n_eff) && lane_idx < 5'(pvp_pkg::WIDE_FIELDS)) begin
                    n_a1[j] = r_wide[lane_idx[3:0]];
                    n_b1[j] = r_narrow[j];
                end
            end else if (kind != pvp_pkg::KIND_BAD && j == 0) begin
                if (r_aidx < 4'(pvp_pkg::WIDE_FIELDS) &&
                    r_bidx < 2'(pvp_pkg::NARROW_FIELDS)) begin
                    n_a1[j] = r_wide[r_aidx];
                    n_b1[j] = r_narrow[r_bidx];
                end
            end
        end
        n_ctl1.ch   = (kind == pvp_pkg::KIND_BAD) ? '0 : r_ch;
        n_ctl1.last = issue_last;
        n_ctl1.bad  = (kind == pvp_pkg::KIND_BAD);
    end

    // Hold the pixel and walk its results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (s_accept) begin
            r_busy <= 1'b1;
        end else if (issue && issue_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            for (int i = 0; i < pvp_pkg::WIDE_FIELDS; i++) begin
                r_wide[i] <= i_s_tdata[i*pvp_pkg::DATA_W +: pvp_pkg::DATA_W];
            end
            for (int i = 0; i < pvp_pkg::NARROW_FIELDS; i++) begin
                r_narrow[i] <= i_s_tdata[(pvp_pkg::WIDE_FIELDS+i)*pvp_pkg::DATA_W +:
                                         pvp_pkg::DATA_W];
            end
            r_aidx <= '0;
            r_bidx <= '0;
            r_ch   <= '0;
        end else if (issue) begin
            r_aidx <= n_aidx;
            r_bidx <= n_bidx;
            r_ch   <= ch_inc;
        end
    end

    // Operand stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (r_en) begin
            r_v1 <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r_a1   <= n_a1;
            r_b1   <= n_b1;
            r_ctl1 <= n_ctl1;
        end
    end

    pvp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_en),
        .i_valid (r_v1),
        .i_a     (r_a1),
        .i_b     (r_b1),
        .i_ctl   (r_ctl1),
        .o_valid (m_valid),
        .o_value (m_value),
        .o_ctl   (m_ctl)
    );

    assign o_m_tvalid = m_valid;
    assign o_m_tdata  = {3'b000, m_ctl.ch, m_value};
    assign o_m_tlast  = m_ctl.last;
    assign o_m_tuser  = m_ctl.bad;

    `PVP_ASSERT_NOW(a_walk_in_range, r_busy, r_ch < total, "issue channel past the pixel's total")
    `PVP_ASSERT_NEXT(a_last_frees, issue && issue_last && !s_accept, !r_busy,
        "issue stage still busy after its last result")
    `PVP_ASSERT_NOW(a_bad_single, o_m_tvalid && o_m_tuser[0],
        o_m_tlast && o_m_tdata[36:0] == 37'd0, "error result not a lone zero result")
    `PVP_ASSERT_NEXT(a_stall_holds_issue, r_busy && !r_en, r_busy && $stable(r_ch),
        "issue walk moved during an output stall")

endmodule

[tb/tb.sv]
// Self-checking testbench of the pixel vector product: stream driver, result checker, predictor.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_WIDE     = 9;
    localparam int MAX_NARROW   = 3;
    localparam int WIDE_LIMIT   = (MAX_WIDE < pvp_pkg::WIDE_FIELDS) ?
                                  MAX_WIDE : pvp_pkg::WIDE_FIELDS;
    localparam int NARROW_LIMIT = (MAX_NARROW < pvp_pkg::NARROW_FIELDS) ?
                                  MAX_NARROW : pvp_pkg::NARROW_FIELDS;
    localparam int RANDOM_PIXELS = 192;

    // Spare mode code, decoded as elementwise
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One pixel as it waits for the driver; hold_for_drain makes the driver
    // wait until every channel in flight has come back.
    typedef struct packed {
        logic [pvp_pkg::NARROW_FIELDS-1:0][pvp_pkg::DATA_W-1:0] narrow;
        logic [pvp_pkg::WIDE_FIELDS-1:0][pvp_pkg::DATA_W-1:0]   wide;
        logic                                                   hold_for_drain;
    } t_pixel;

    // One expected output channel
    typedef struct packed {
        pvp_pkg::t_value          value;
        logic [pvp_pkg::CH_W-1:0] ch;
        logic                     last;
        logic                     bad;
    } t_chan_result;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic [191:0] i_s_tdata   = '0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [39:0]  o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [3:0]   i_cfg_data  = '0;

    // Shadow copy of the configuration registers
    logic [1:0] cfg_mode   = pvp_pkg::MODE_ELEM;
    logic [3:0] cfg_wide   = 4'd3;
    logic [1:0] cfg_narrow = 2'd1;

    t_pixel       pending_pixels[$];
    t_chan_result expected_chans[$];
    t_pixel       src_pixel;
    int           src_wait   = 0;
    int           src_calm   = 0;
    int           sink_wait  = 0;
    int           sink_calm  = 0;
    int           fail_count = 0;
    int           pixels_taken   = 0;
    int           chans_checked  = 0;
    int           shape_errors   = 0;
    int           saturated_sums = 0;
    int           settings_used  = 0;

    pixel_vector_product_top #(
        .MAX_WIDE   (MAX_WIDE),
        .MAX_NARROW (MAX_NARROW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock
    always #10 i_clk = ~i_clk;

    // Draw a wait for one request; now and then run a stretch with no waits
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic longint to_q88(input logic [pvp_pkg::DATA_W-1:0] x);
        return longint'($signed(x));
    endfunction

    // Append one pixel to the driver's queue
    function automatic void queue_pixel(input t_pixel p);
        pending_pixels = {pending_pixels, p};
    endfunction

    // Clip to the Q16.16 range and queue one expected channel
    function automatic void push_chan(input longint v, input int ch, input bit last);
        t_chan_result r;
        if (v > longint'(32'sh7fffffff)) begin
            v = longint'(32'sh7fffffff);
            saturated_sums++;
        end else if (v < -longint'(33'sh080000000)) begin
            v = -longint'(33'sh080000000);
            saturated_sums++;
        end
        r.value = pvp_pkg::t_value'(v);
        r.ch    = ch[pvp_pkg::CH_W-1:0];
        r.last  = last;
        r.bad   = 1'b0;
        expected_chans = {expected_chans, r};
    endfunction

    // Work out every output channel one pixel produces under the shadow config
    function automatic void compute_channels(input t_pixel p);
        int           w;
        int           n;
        int           rows;
        longint       acc;
        t_chan_result r;
        if (cfg_wide == 0) w = 1;
        else if (cfg_wide > WIDE_LIMIT) w = WIDE_LIMIT;
        else w = cfg_wide;
        if (cfg_narrow == 0) n = 1;
        else if (cfg_narrow > NARROW_LIMIT) n = NARROW_LIMIT;
        else n = cfg_narrow;

        // uneven shape: a single flagged result
        if (w % n != 0) begin
            r.value = '0;
            r.ch    = '0;
            r.last  = 1'b1;
            r.bad   = 1'b1;
            expected_chans = {expected_chans, r};
            shape_errors++;
            return;
        end

        if (n == 1 || (cfg_mode != pvp_pkg::MODE_INNER && cfg_mode != pvp_pkg::MODE_OUTER)) begin
            // scalar or elementwise: narrow channels repeat
            for (int i = 0; i < w; i++)
                push_chan(to_q88(p.wide[i]) * to_q88(p.narrow[i % n]), i, i == w - 1);
        end else if (cfg_mode == pvp_pkg::MODE_INNER) begin
            // one saturated dot product per matrix row
            rows = w / n;
            for (int i = 0; i < rows; i++) begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    acc += to_q88(p.wide[i * n + j]) * to_q88(p.narrow[j]);
                push_chan(acc, i, i == rows - 1);
            end
        end else begin
            // every pair, wide index outer
            for (int i = 0; i < w; i++)
                for (int j = 0; j < n; j++)
                    push_chan(to_q88(p.wide[i]) * to_q88(p.narrow[j]), i * n + j,
                              i * n + j == w * n - 1);
        end
    endfunction

    // Compare one accepted result with the oldest expectation
    task automatic check_channel();
        t_chan_result want;
        if (expected_chans.size() == 0) begin
            $error("unexpected output channel: product_value %0d out_channel %0d",
                   $signed(o_m_tdata[31:0]), o_m_tdata[36:32]);
            fail_count++;
            return;
        end
        want = expected_chans.pop_front();
        chans_checked++;
        if (o_m_tdata[31:0] !== want.value) begin
            $error("product_value: expected %0d, got %0d", want.value, $signed(o_m_tdata[31:0]));
            fail_count++;
        end
        if (o_m_tdata[36:32] !== want.ch) begin
            $error("out_channel: expected %0d, got %0d", want.ch, o_m_tdata[36:32]);
            fail_count++;
        end
        if (o_m_tlast !== want.last) begin
            $error("last_channel: expected %0d, got %0d", want.last, o_m_tlast);
            fail_count++;
        end
        if (o_m_tuser[0] !== want.bad) begin
            $error("bad_shape: expected %0d, got %0d", want.bad, o_m_tuser[0]);
            fail_count++;
        end
    endtask

    // Pixel driver: predict on acceptance, then present the next queued pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                compute_channels(src_pixel);
                pixels_taken++;
                src_wait = pick_wait(src_calm);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_pixels.size() != 0 &&
                             !(pending_pixels[0].hold_for_drain &&
                               expected_chans.size() != 0)) begin
                    src_pixel = pending_pixels.pop_front();
                    i_s_tdata  <= {src_pixel.narrow, src_pixel.wide};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted channel, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                check_channel();
                sink_wait = pick_wait(sink_calm);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [pvp_pkg::DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        for (int i = 0; i < pvp_pkg::WIDE_FIELDS; i++) p.wide[i] = rand_sample();
        for (int j = 0; j < pvp_pkg::NARROW_FIELDS; j++) p.narrow[j] = rand_sample();
        p.hold_for_drain = ($urandom_range(0, 24) == 0);
        return p;
    endfunction

    function automatic t_pixel flat_pixel(input logic [pvp_pkg::DATA_W-1:0] w,
                                          input logic [pvp_pkg::DATA_W-1:0] n);
        t_pixel p;
        for (int i = 0; i < pvp_pkg::WIDE_FIELDS; i++) p.wide[i] = w;
        for (int j = 0; j < pvp_pkg::NARROW_FIELDS; j++) p.narrow[j] = n;
        p.hold_for_drain = 1'b0;
        return p;
    endfunction

    // Wait until no pixel is queued or in flight and no channel is outstanding;
    // sample between edges so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || i_s_tvalid || expected_chans.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write request; update the shadow copy when it is taken
    task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            pvp_pkg::CFG_MODE:   cfg_mode   = data[1:0];
            pvp_pkg::CFG_WIDE:   cfg_wide   = data;
            pvp_pkg::CFG_NARROW: cfg_narrow = data[1:0];
            default:    ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // Drain, then load a new setting; unused upper data bits get random values
    task automatic set_product(input logic [1:0] m, input logic [3:0] w, input logic [1:0] n);
        logic [1:0] junk;
        wait_idle();
        junk = 2'($urandom);
        write_reg(pvp_pkg::CFG_MODE, {junk, m});
        write_reg(pvp_pkg::CFG_WIDE, w);
        junk = 2'($urandom);
        write_reg(pvp_pkg::CFG_NARROW, {junk, n});
        settings_used++;
    endtask

    // Reset, then directed settings, then random settings
    initial begin
        t_pixel     p;
        logic [1:0] m;
        logic [3:0] w;
        logic [1:0] n;
        int         burst;
        int         queued;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: scalar product over three channels
        queue_pixel(flat_pixel(16'h7fff, 16'h7fff));
        queue_pixel(flat_pixel(16'h8000, 16'h8000));
        queue_pixel(flat_pixel(16'h8000, 16'h7fff));
        settings_used++;

        // elementwise, full width
        set_product(pvp_pkg::MODE_ELEM, 4'd9, 2'd3);
        queue_pixel(flat_pixel(16'h8000, 16'h0001));
        queue_pixel(rand_pixel());

        // inner sums hitting both saturation limits
        set_product(pvp_pkg::MODE_INNER, 4'd9, 2'd3);
        queue_pixel(flat_pixel(16'h7fff, 16'h7fff));
        queue_pixel(flat_pixel(16'h8000, 16'h7fff));
        queue_pixel(flat_pixel(16'h8000, 16'h8000));

        // outer product, largest result count
        set_product(pvp_pkg::MODE_OUTER, 4'd9, 2'd3);
        queue_pixel(flat_pixel(16'hffff, 16'h8000));
        queue_pixel(rand_pixel());

        set_product(pvp_pkg::MODE_INNER, 4'd6, 2'd2);
        queue_pixel(rand_pixel());

        // mode three acts as elementwise
        set_product(MODE_SPARE, 4'd6, 2'd3);
        queue_pixel(rand_pixel());

        // single narrow channel turns inner into a scalar product
        set_product(pvp_pkg::MODE_INNER, 4'd4, 2'd1);
        queue_pixel(rand_pixel());

        // zero wide channels count as one
        set_product(pvp_pkg::MODE_OUTER, 4'd0, 2'd1);
        queue_pixel(flat_pixel(16'h8000, 16'h8000));

        // too many wide channels clip to nine
        set_product(pvp_pkg::MODE_ELEM, 4'd15, 2'd3);
        queue_pixel(rand_pixel());

        // zero narrow channels count as one
        set_product(pvp_pkg::MODE_OUTER, 4'd4, 2'd0);
        queue_pixel(rand_pixel());

        // uneven shape, and narrow wider than wide
        set_product(pvp_pkg::MODE_INNER, 4'd4, 2'd3);
        queue_pixel(rand_pixel());
        set_product(pvp_pkg::MODE_OUTER, 4'd2, 2'd3);
        queue_pixel(rand_pixel());

        set_product(pvp_pkg::MODE_ELEM, 4'd1, 2'd1);
        queue_pixel(flat_pixel(16'h7fff, 16'h8000));

        // random settings, mostly well-formed shapes
        queued = 0;
        while (queued < RANDOM_PIXELS) begin
            m = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 4) != 0) begin
                n = 2'($urandom_range(1, 3));
                w = 4'(n * $urandom_range(1, 9 / n));
            end else begin
                n = 2'($urandom_range(0, 3));
                w = 4'($urandom_range(0, 15));
            end
            set_product(m, w, n);
            burst = $urandom_range(8, 24);
            for (int k = 0; k < burst; k++) begin
                p = rand_pixel();
                queue_pixel(p);
            end
            queued += burst;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d pixels over %0d register settings, %0d channels checked,",
                 pixels_taken, settings_used, chans_checked);
        $display("  including %0d shape-error results and %0d saturated values.",
                 shape_errors, saturated_sums);
        if (fail_count == 0) begin
            $display("PASS pixel_vector_product_top");
        end else begin
            $display("FAIL pixel_vector_product_top");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("FAIL pixel_vector_product_top");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/pvp_pkg.sv
sv/pvp_mac.sv
sv/pixel_vector_product_top.sv
tb/tb.sv
